[rtl/acgs_pkg.sv]
package acgs_pkg;

    // Configuration register indexes
    typedef enum logic [7:0] {
        REG_GAIN      = 8'd0,
        REG_THRESHOLD = 8'd1,
        REG_INV_RATIO = 8'd2,
        REG_ENABLE    = 8'd3
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [15:0] GAIN_RESET      = 16'd3840;      // 15.0 in Q8.8
    localparam logic [30:0] THRESHOLD_RESET = 31'd10000000;
    localparam logic [16:0] INV_RATIO_RESET = 17'd65536;     // ratio 1
    localparam logic        ENABLE_RESET    = 1'b1;

    // Saturation limits on the magnitude
    localparam logic [41:0] POS_LIMIT = 42'h0_7FFF_FFFF;
    localparam logic [41:0] NEG_LIMIT = 42'h0_8000_0000;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [15:0] gain_q8;
        logic [30:0] comp_threshold;
        logic [16:0] inv_ratio_q16;
        logic        compress_enable;
    } cfg_t;

    // Compressed item handed to the gain stages
    typedef struct packed {
        logic        neg;
        logic        last;
        logic [33:0] cmag;
    } mid_t;

    // Stage load enables
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } cmp_en_t;

    typedef struct packed {
        logic ld4;
        logic ld5;
    } gain_en_t;

endpackage

[rtl/acgs_compress.sv]
module acgs_compress
    import acgs_pkg::*;
(
    input  logic        clk,
    input  cmp_en_t     en,
    input  cfg_t        cfg,
    input  logic [31:0] sample,
    input  logic        last,
    output mid_t        mid
);

    // Stage 1 registers
    logic        s1_neg_reg, s1_last_reg, s1_over_reg;
    logic [31:0] s1_mag_reg, s1_excess_reg;
    // Stage 2 registers
    logic        s2_neg_reg, s2_last_reg, s2_over_reg;
    logic [31:0] s2_mag_reg;
    logic [32:0] s2_scaled_reg;
    // Stage 3 register
    mid_t        s3_reg;

    logic [31:0] mag_next;
    logic        over_next;
    logic [31:0] excess_next;
    logic [48:0] prod;
    logic [33:0] cmag_next;

    // Stage 1: magnitude, threshold compare, excess
    assign mag_next    = sample[31] ? (~sample + 32'd1) : sample;
    assign over_next   = cfg.compress_enable && (mag_next > {1'b0, cfg.comp_threshold});
    assign excess_next = mag_next - {1'b0, cfg.comp_threshold};

    // Stage 2: excess scaled by the reciprocal ratio
    assign prod = 49'(s1_excess_reg) * 49'(cfg.inv_ratio_q16);

    // Stage 3: threshold added back, or the plain magnitude passed on
    assign cmag_next = s2_over_reg
        ? (34'(cfg.comp_threshold) + 34'(s2_scaled_reg))
        : 34'(s2_mag_reg);

    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            s1_neg_reg    <= sample[31];
            s1_last_reg   <= last;
            s1_over_reg   <= over_next;
            s1_mag_reg    <= mag_next;
            s1_excess_reg <= excess_next;
        end
        if (en.ld2)
        begin
            s2_neg_reg    <= s1_neg_reg;
            s2_last_reg   <= s1_last_reg;
            s2_over_reg   <= s1_over_reg;
            s2_mag_reg    <= s1_mag_reg;
            s2_scaled_reg <= prod[48:16];
        end
        if (en.ld3)
        begin
            s3_reg.neg  <= s2_neg_reg;
            s3_reg.last <= s2_last_reg;
            s3_reg.cmag <= cmag_next;
        end
    end

    assign mid = s3_reg;

endmodule

[rtl/acgs_gain.sv]
module acgs_gain
    import acgs_pkg::*;
(
    input  logic        clk,
    input  gain_en_t    en,
    input  logic [15:0] gain_q8,
    input  mid_t        mid,
    output logic [31:0] sample,
    output logic        clipped,
    output logic        last
);

    logic        s4_neg_reg, s4_last_reg;
    logic [41:0] s4_amp_reg;
    logic [31:0] s5_sample_reg;
    logic        s5_clipped_reg, s5_last_reg;

    logic [49:0] prod;
    logic        clip_next;
    logic [31:0] mag_sat;
    logic [31:0] sample_next;

    // Stage 4: gain multiply, Q8.8 truncated
    assign prod = 50'(mid.cmag) * 50'(gain_q8);

    // Stage 5: saturate on magnitude, then restore sign
    always_comb
    begin
        if (s4_neg_reg)
        begin
            clip_next = s4_amp_reg > NEG_LIMIT;
            mag_sat   = clip_next ? NEG_LIMIT[31:0] : s4_amp_reg[31:0];
        end
        else
        begin
            clip_next = s4_amp_reg > POS_LIMIT;
            mag_sat   = clip_next ? POS_LIMIT[31:0] : s4_amp_reg[31:0];
        end
        sample_next = s4_neg_reg ? (32'd0 - mag_sat) : mag_sat;
    end

    always_ff @(posedge clk)
    begin
        if (en.ld4)
        begin
            s4_neg_reg  <= mid.neg;
            s4_last_reg <= mid.last;
            s4_amp_reg  <= prod[49:8];
        end
        if (en.ld5)
        begin
            s5_sample_reg  <= sample_next;
            s5_clipped_reg <= clip_next;
            s5_last_reg    <= s4_last_reg;
        end
    end

    assign sample  = s5_sample_reg;
    assign clipped = s5_clipped_reg;
    assign last    = s5_last_reg;

endmodule

[rtl/audio_compress_gain_saturate_unit.sv]
// Hard-knee compressor with saturating gain. With compression enabled, each
// signed 32-bit sample above the threshold in magnitude has its excess
// scaled by inv_ratio_q16 (Q1.16), then the result is multiplied by gain_q8
// (Q8.8), truncated toward zero and saturated to 32 bits; m_tuser flags a
// saturated sample and tlast passes through. The block takes one sample per
// clock while the output is not stalled and has five register stages
// (magnitude and compare, ratio multiply, threshold add, gain multiply,
// saturation); the last stage is the output register. Each stage holds its
// item under back-pressure and keeps taking new ones while it has room.
// Configuration writes are always accepted and take effect at once; write
// them only while the pipeline is empty.
module audio_compress_gain_saturate_unit
    import acgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sample_in
    input  logic        s_tlast,
    // Sample output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] sample_out
    output logic        m_tuser,    // [0] clipped
    output logic        m_tlast,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NUM_STAGES = 5;

    cfg_t                  cfg_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;
    cmp_en_t               cmp_en;
    gain_en_t              gain_en;
    mid_t                  mid;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_q8         <= GAIN_RESET;
            cfg_reg.comp_threshold  <= THRESHOLD_RESET;
            cfg_reg.inv_ratio_q16   <= INV_RATIO_RESET;
            cfg_reg.compress_enable <= ENABLE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_GAIN:      cfg_reg.gain_q8         <= cfg_data[15:0];
                REG_THRESHOLD: cfg_reg.comp_threshold  <= cfg_data[30:0];
                REG_INV_RATIO: cfg_reg.inv_ratio_q16   <= cfg_data[16:0];
                REG_ENABLE:    cfg_reg.compress_enable <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    assign cmp_en.ld1  = adv[0];
    assign cmp_en.ld2  = adv[1];
    assign cmp_en.ld3  = adv[2];
    assign gain_en.ld4 = adv[3];
    assign gain_en.ld5 = adv[4];

    // Compression stages
    acgs_compress u_compress (
        .clk    (clk),
        .en     (cmp_en),
        .cfg    (cfg_reg),
        .sample (s_tdata),
        .last   (s_tlast),
        .mid    (mid)
    );

    // Gain and saturation stages
    acgs_gain u_gain (
        .clk     (clk),
        .en      (gain_en),
        .gain_q8 (cfg_reg.gain_q8),
        .mid     (mid),
        .sample  (m_tdata),
        .clipped (m_tuser),
        .last    (m_tlast)
    );

    // A saturated sample sits at one of the two limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
        else $error("clipped sample not at a limit");

    // Input back-pressure only when the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    // An accepted sample into an empty pipe with a ready output reaches the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && valid_reg == '0 && m_tready) |=> ##4 m_tvalid)
        else $error("sample lost in pipeline");

endmodule
